FILE: src/cpb_pkg.sv
// Shared types, constants and fixed-point helpers for the cascaded PD balance controller.
`timescale 1ns / 1ps

package cpb_pkg;

  // Stream payload widths (fields packed from bit 0, padded to whole bytes)
  localparam int unsigned IN_W  = 48;
  localparam int unsigned OUT_W = 16;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 17;

  // Control constants
  localparam int unsigned DRIVE_LIMIT     = 6900;
  localparam int unsigned POSITION_DIVIDE = 5;
  localparam int unsigned ANGLE_WINDOW    = 500;
  localparam int unsigned MIN_VOLTAGE     = 700;

  // Register reset values
  localparam logic [11:0] ANGLE_CENTER_RST  = 12'd2048;
  localparam logic [15:0] POS_TARGET_RST    = 16'd10000;
  localparam logic [16:0] ANGLE_KP_RST      = 17'd53760;
  localparam logic [16:0] ANGLE_KD_RST      = 17'd38400;
  localparam logic [15:0] POS_KP_RST        = 16'd2048;
  localparam logic [16:0] POS_KD_RST        = 17'd33280;

  // ceil(2^30 / 5): exact quotient for magnitudes below 2^30
  localparam logic [27:0] DIV5_RECIP = 28'd214748365;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ANGLE_CENTER  = 3'd0,
    REG_POS_TARGET    = 3'd1,
    REG_ANGLE_KP      = 3'd2,
    REG_ANGLE_KD      = 3'd3,
    REG_POS_KP        = 3'd4,
    REG_POS_KD        = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [11:0] angle_center;
    logic [15:0] pos_target;
    logic [16:0] angle_kp;
    logic [16:0] angle_kd;
    logic [15:0] pos_kp;
    logic [16:0] pos_kd;
  } cfg_t;

  // Signed divide by 5, truncated toward zero, via reciprocal multiply.
  function automatic logic signed [27:0] div5_trunc(input logic signed [27:0] x);
    logic [27:0] mag;
    logic [55:0] prod;
    logic [27:0] quo;
    mag  = x[27] ? (~x + 28'd1) : x;
    prod = 56'(mag) * 56'(DIV5_RECIP);
    quo  = {2'b00, prod[55:30]};
    return x[27] ? $signed(~quo + 28'd1) : $signed(quo);
  endfunction

endpackage

FILE: src/cpb_cfg_regs.sv
// Configuration register file for the cascaded PD balance controller.
`timescale 1ns / 1ps

module cpb_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [cpb_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [cpb_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output cpb_pkg::cfg_t                   cfg_o
);
  import cpb_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_ANGLE_CENTER:  cfg_d.angle_center  = cfg_data_i[11:0];
        REG_POS_TARGET:    cfg_d.pos_target    = cfg_data_i[15:0];
        REG_ANGLE_KP:      cfg_d.angle_kp      = cfg_data_i;
        REG_ANGLE_KD:      cfg_d.angle_kd      = cfg_data_i;
        REG_POS_KP:        cfg_d.pos_kp        = cfg_data_i[15:0];
        REG_POS_KD:        cfg_d.pos_kd        = cfg_data_i;
        default:           cfg_d = cfg_q; // unmapped index, dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.angle_center  <= ANGLE_CENTER_RST;
      cfg_q.pos_target    <= POS_TARGET_RST;
      cfg_q.angle_kp      <= ANGLE_KP_RST;
      cfg_q.angle_kd      <= ANGLE_KD_RST;
      cfg_q.pos_kp        <= POS_KP_RST;
      cfg_q.pos_kd        <= POS_KD_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: src/cascaded_pd_pendulum_balance.sv
// Top level of the cascaded PD inverted-pendulum balance controller.
// One control tick per input transfer: angle sample, cart encoder count, supply
// voltage and a start request. The block returns exactly one result per tick
// (reverse, duty, stopped) in order. It takes a new tick every clock cycle
// unless a stalled output has filled the pipeline; a tick passes through five
// pipeline stages plus the output register. Backpressure ripples stage
// by stage, so bubbles are squeezed out and input keeps flowing while a result
// waits on the output. The stop latch, the angle history and the decimation
// counter update at input transfer; the position filter state is read and
// written in stage 2 and the held position term in stage 4, so the position
// loop stays exact at any decimation ratio. The stop latch is set after reset:
// send a tick with start_req high to run. Configuration writes take effect on
// the next cycle and are meant to happen while the pipeline is empty.
`timescale 1ns / 1ps

module cascaded_pd_pendulum_balance (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input: [11:0] angle_sample, [27:12] encoder_count, [43:28] supply_voltage,
  //        [44] start_req, [47:45] zero
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [cpb_pkg::IN_W-1:0]        s_axis_tdata,
  // output: [0] reverse, [13:1] duty, [14] stopped, [15] zero
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [cpb_pkg::OUT_W-1:0]       m_axis_tdata,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [cpb_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [cpb_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import cpb_pkg::*;

  localparam logic signed [12:0] WIN_HI   = 13'(ANGLE_WINDOW);
  localparam logic signed [12:0] WIN_LO   = -13'(ANGLE_WINDOW);
  localparam logic signed [28:0] LIMIT_HI = 29'(DRIVE_LIMIT);
  localparam logic signed [28:0] LIMIT_LO = -29'(DRIVE_LIMIT);

  typedef struct packed {
    logic               stp;
    logic               upd;
    logic signed [12:0] e;
    logic signed [13:0] d;
    logic signed [16:0] l;
  } s1_t;

  typedef struct packed {
    logic               stp;
    logic               upd;
    logic signed [30:0] pa;
    logic signed [31:0] pd;
    logic signed [24:0] ql;
  } s2_t;

  typedef struct packed {
    logic               stp;
    logic               upd;
    logic signed [24:0] bal;
    logic signed [24:0] f;
    logic signed [25:0] df;
  } s3_t;

  typedef struct packed {
    logic               stp;
    logic               upd;
    logic signed [24:0] bal;
    logic signed [41:0] pp;
    logic signed [43:0] pdd;
  } s4_t;

  typedef struct packed {
    logic               stp;
    logic signed [28:0] moto;
  } s5_t;

  cfg_t cfg;

  cpb_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // ---------------------------------------------------------------------------
  // Input unpack and per-tick state (stop latch, angle history, decimation)
  // ---------------------------------------------------------------------------
  logic [11:0] angle_in;
  logic [15:0] enc_in;
  logic [15:0] volt_in;
  logic        start_in;

  assign angle_in = s_axis_tdata[11:0];
  assign enc_in   = s_axis_tdata[27:12];
  assign volt_in  = s_axis_tdata[43:28];
  assign start_in = s_axis_tdata[44];

  logic               latch_q, latch_d;
  logic signed [12:0] prev_e_q;
  logic [2:0]         cnt_q, cnt_d;
  logic signed [24:0] f_q;
  logic signed [27:0] held_q;

  logic               v1_q, v2_q, v3_q, v4_q, v5_q, vo_q;
  logic               rdy1, rdy2, rdy3, rdy4, rdy5, rdyo;
  s1_t                s1_q, s1_d;
  s2_t                s2_q, s2_d;
  s3_t                s3_q, s3_d;
  s4_t                s4_q, s4_d;
  s5_t                s5_q, s5_d;
  logic [OUT_W-1:0]   out_q, out_d;

  logic               s_fire;
  logic               tick_latch;
  logic               in_window;
  logic [2:0]         cnt_inc;
  logic               f_fire, held_fire;

  // ready ripples back from the output register
  assign rdyo = !vo_q || m_axis_tready;
  assign rdy5 = !v5_q || rdyo;
  assign rdy4 = !v4_q || rdy5;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign s_axis_tready = rdy1;
  assign s_fire        = s_axis_tvalid && rdy1;

  always_comb begin
    s1_d.e     = $signed({1'b0, angle_in}) - $signed({1'b0, cfg.angle_center});
    s1_d.d     = {s1_d.e[12], s1_d.e} - {prev_e_q[12], prev_e_q};
    s1_d.l     = $signed({1'b0, enc_in}) - $signed({1'b0, cfg.pos_target});
    in_window  = (s1_d.e > WIN_LO) && (s1_d.e < WIN_HI);
    // start clears first, then the window and supply checks may set again
    tick_latch = (latch_q && !start_in) || !in_window || (volt_in < 16'(MIN_VOLTAGE));
    cnt_inc    = cnt_q + 3'd1;
    s1_d.stp   = tick_latch;
    s1_d.upd   = (cnt_inc >= 3'(POSITION_DIVIDE));
    latch_d    = s_fire ? tick_latch : latch_q;
    cnt_d      = cnt_q;
    if (s_fire && !tick_latch) begin
      cnt_d = s1_d.upd ? 3'd0 : cnt_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latch_q  <= 1'b1;
      prev_e_q <= '0;
      cnt_q    <= '0;
    end else begin
      latch_q <= latch_d;
      cnt_q   <= cnt_d;
      if (s_fire && !tick_latch) begin
        prev_e_q <= s1_d.e;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1 -> 2: angle gain products, position sample scaled by 256/5
  // ---------------------------------------------------------------------------
  logic signed [27:0] ql_full;

  always_comb begin
    s2_d.stp = s1_q.stp;
    s2_d.upd = s1_q.upd;
    s2_d.pa  = s1_q.e * $signed({1'b0, cfg.angle_kp});
    s2_d.pd  = s1_q.d * $signed({1'b0, cfg.angle_kd});
    ql_full  = div5_trunc({{3{s1_q.l[16]}}, s1_q.l, 8'h00});
    s2_d.ql  = ql_full[24:0];
  end

  // ---------------------------------------------------------------------------
  // Stage 2 -> 3: angle term, low-pass filter update (f' = 0.8 f + 0.2 * 256 l)
  // ---------------------------------------------------------------------------
  logic signed [30:0] pa_adj;
  logic signed [31:0] pd_adj;
  logic signed [27:0] f_scaled;
  logic signed [25:0] f_sum;

  always_comb begin
    // truncate toward zero: bias negatives before the arithmetic shift
    pa_adj   = s2_q.pa + $signed({23'd0, {8{s2_q.pa[30]}}});
    pd_adj   = s2_q.pd + $signed({24'd0, {8{s2_q.pd[31]}}});
    s3_d.stp = s2_q.stp;
    s3_d.upd = s2_q.upd;
    s3_d.bal = 25'sd0 - {{2{pa_adj[30]}}, pa_adj[30:8]} - {pd_adj[31], pd_adj[31:8]};
    f_scaled = div5_trunc({f_q[24], f_q, 2'b00});
    f_sum    = f_scaled[25:0] + {s2_q.ql[24], s2_q.ql};
    s3_d.f   = f_sum[24:0];  // filter stays within +-2^24
    s3_d.df  = {s3_d.f[24], s3_d.f} - {f_q[24], f_q};
  end

  assign f_fire = v2_q && rdy3 && !s2_q.stp && s2_q.upd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_q <= '0;
    end else if (f_fire) begin
      f_q <= s3_d.f;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3 -> 4: position gain products
  // ---------------------------------------------------------------------------
  always_comb begin
    s4_d.stp = s3_q.stp;
    s4_d.upd = s3_q.upd;
    s4_d.bal = s3_q.bal;
    s4_d.pp  = s3_q.f * $signed({1'b0, cfg.pos_kp});
    s4_d.pdd = s3_q.df * $signed({1'b0, cfg.pos_kd});
  end

  // ---------------------------------------------------------------------------
  // Stage 4 -> 5: position term (held between updates), drive sum
  // ---------------------------------------------------------------------------
  logic signed [41:0] pp_adj;
  logic signed [43:0] pdd_adj;
  logic signed [27:0] held_new;
  logic signed [27:0] held_sel;

  always_comb begin
    pp_adj    = s4_q.pp + $signed({26'd0, {16{s4_q.pp[41]}}});
    pdd_adj   = s4_q.pdd + $signed({28'd0, {16{s4_q.pdd[43]}}});
    held_new  = {{2{pp_adj[41]}}, pp_adj[41:16]} + pdd_adj[43:16];
    held_sel  = s4_q.upd ? held_new : held_q;
    s5_d.stp  = s4_q.stp;
    s5_d.moto = {{4{s4_q.bal[24]}}, s4_q.bal} - {held_sel[27], held_sel};
  end

  assign held_fire = v4_q && rdy5 && !s4_q.stp && s4_q.upd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
    end else if (held_fire) begin
      held_q <= held_new;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5 -> output: clamp, sign/magnitude
  // ---------------------------------------------------------------------------
  logic signed [28:0] moto_clamp;
  logic signed [28:0] moto_mag;

  always_comb begin
    moto_clamp = s5_q.moto;
    if (s5_q.moto > LIMIT_HI) begin
      moto_clamp = LIMIT_HI;
    end else if (s5_q.moto < LIMIT_LO) begin
      moto_clamp = LIMIT_LO;
    end
    moto_mag = moto_clamp[28] ? (29'sd0 - moto_clamp) : moto_clamp;
    if (s5_q.stp) begin
      out_d = {1'b0, 1'b1, 13'd0, 1'b0};
    end else begin
      out_d = {1'b0, 1'b0, moto_mag[12:0], moto_clamp[28]};
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline valid bits and payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
      if (rdyo) vo_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) s1_q  <= s1_d;
    if (rdy2) s2_q  <= s2_d;
    if (rdy3) s3_q  <= s3_d;
    if (rdy4) s4_q  <= s4_d;
    if (rdy5) s5_q  <= s5_d;
    if (rdyo) out_q <= out_d;
  end

  assign m_axis_tvalid = vo_q;
  assign m_axis_tdata  = out_q;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q < 3'(POSITION_DIVIDE))
    else $error("decimation counter out of range");

  a_stop_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && tick_latch) |=> ($stable(prev_e_q) && $stable(cnt_q)))
    else $error("loop state changed on a stopped tick");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output register");

  a_held_only_on_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(held_q) |-> $past(held_fire))
    else $error("held position term changed without a position update");
`endif

endmodule
